// File: sv/brt_pkg.sv
// shared types, codes and defaults for the bond record table
package brt_pkg;

	localparam int KEY_TABLE_DEPTH_DEF = 8;
	localparam int SUB_TABLE_DEPTH_DEF = 8;
	localparam int PAYLOAD_BITS_DEF    = 64;

	localparam logic [1:0] MODE_READ   = 2'd0;
	localparam logic [1:0] MODE_WRITE  = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;

	localparam logic [1:0] TBL_OWN  = 2'd0;
	localparam logic [1:0] TBL_PEER = 2'd1;
	localparam logic [1:0] TBL_SUB  = 2'd2;
	localparam logic [1:0] TBL_BAD  = 2'd3;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_TABLE = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  table_req;
		logic [1:0]  address_type;
		logic [47:0] address;
		logic [2:0]  match_skip;
		logic [15:0] handle;
		logic [63:0] payload;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  found_address_type;
		logic [47:0] found_address;
		logic [15:0] found_handle;
		logic [63:0] found_payload;
		logic [3:0]  entry_count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_FIN
	} state_t;

	typedef struct packed {
		logic    capture;
		logic    clr_scan;
		logic    rd_cur;
		logic    rd_next;
		logic    inc_idx;
		logic    inc_seen;
		logic    wr_req;
		logic    inc_fill;
		logic    wr_shift;
		logic    dec_fill;
		logic    load_found;
		logic    set_status;
		status_t status_code;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic tbl_bad;
		logic mode_bad;
		logic is_read;
		logic is_write;
		logic scan_end;
		logic hit;
		logic skip_more;
		logic full;
		logic shift_end;
		logic out_free;
	} sts_t;

endpackage

// File: sv/brt_ctrl.sv
// sequencer for lookup, update, append and delete with shift
module brt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  brt_pkg::sts_t sts,
	output brt_pkg::cmd_t cmd
);
	import brt_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_nxt = S_START;
			end
			S_START: begin
				if (sts.tbl_bad || sts.mode_bad) state_nxt = S_FIN;
				else state_nxt = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (sts.scan_end) state_nxt = S_FIN;
				else state_nxt = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (!sts.hit || sts.skip_more) state_nxt = S_SCAN_RD;
				else if (sts.is_read || sts.is_write) state_nxt = S_FIN;
				else state_nxt = S_SHIFT_RD;
			end
			S_SHIFT_RD: begin
				if (sts.shift_end) state_nxt = S_FIN;
				else state_nxt = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				state_nxt = S_SHIFT_RD;
			end
			S_FIN: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.status_code = ST_OK;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.capture = req_valid;
			end
			S_START: begin
				if (sts.tbl_bad) begin
					cmd.set_status = 1'b1;
					cmd.status_code = ST_BAD_TABLE;
				end else if (sts.mode_bad) begin
					cmd.set_status = 1'b1;
					cmd.status_code = ST_NOT_FOUND;
				end else begin
					cmd.clr_scan = 1'b1;
				end
			end
			S_SCAN_RD: begin
				if (sts.scan_end) begin
					cmd.set_status = 1'b1;
					if (!sts.is_write) begin
						cmd.status_code = ST_NOT_FOUND;
					end else if (sts.full) begin
						cmd.status_code = ST_FULL;
					end else begin
						// append: scan index equals the fill count here
						cmd.wr_req = 1'b1;
						cmd.inc_fill = 1'b1;
						cmd.status_code = ST_OK;
					end
				end else begin
					cmd.rd_cur = 1'b1;
				end
			end
			S_SCAN_CHK: begin
				if (!sts.hit) begin
					cmd.inc_idx = 1'b1;
				end else if (sts.skip_more) begin
					cmd.inc_idx = 1'b1;
					cmd.inc_seen = 1'b1;
				end else if (sts.is_read) begin
					cmd.load_found = 1'b1;
					cmd.set_status = 1'b1;
				end else if (sts.is_write) begin
					cmd.wr_req = 1'b1;
					cmd.set_status = 1'b1;
				end
			end
			S_SHIFT_RD: begin
				if (sts.shift_end) begin
					cmd.dec_fill = 1'b1;
					cmd.set_status = 1'b1;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			S_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.inc_idx = 1'b1;
			end
			S_FIN: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: sv/brt_dpath.sv
// entry store, table counts, scan counters, match logic and result register
module brt_dpath #(
	parameter int KEY_TABLE_DEPTH = brt_pkg::KEY_TABLE_DEPTH_DEF,
	parameter int SUB_TABLE_DEPTH = brt_pkg::SUB_TABLE_DEPTH_DEF,
	parameter int PAYLOAD_BITS    = brt_pkg::PAYLOAD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  brt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output brt_pkg::rsp_t rsp,
	input  brt_pkg::cmd_t cmd,
	output brt_pkg::sts_t sts
);
	import brt_pkg::*;

	localparam int STORE_DEPTH = 2 * KEY_TABLE_DEPTH + SUB_TABLE_DEPTH;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int MAX_DEPTH   = (KEY_TABLE_DEPTH > SUB_TABLE_DEPTH) ?
		KEY_TABLE_DEPTH : SUB_TABLE_DEPTH;
	localparam int CW          = $clog2(MAX_DEPTH + 1);

	// entry store, no reset: never read past a table's count
	logic [49:0]             mem_addr [STORE_DEPTH];
	logic [15:0]             mem_hdl  [STORE_DEPTH];
	logic [PAYLOAD_BITS-1:0] mem_pay  [STORE_DEPTH];

	req_t                    req_q;
	logic [CW-1:0]           idx_q;
	logic [2:0]              seen_q;
	logic [CW-1:0]           fill_q [3];
	logic [49:0]             rd_addr_q;
	logic [15:0]             rd_hdl_q;
	logic [PAYLOAD_BITS-1:0] rd_pay_q;
	logic [49:0]             found_addr_q;
	logic [15:0]             found_hdl_q;
	logic [PAYLOAD_BITS-1:0] found_pay_q;
	logic [1:0]              status_q;
	rsp_t                    rsp_q;
	logic                    rsp_valid_q;

	logic [AW-1:0]           base;
	logic [AW-1:0]           mem_a;
	logic [CW-1:0]           fill_sel;
	logic [CW-1:0]           cap_sel;
	logic [49:0]             key;
	logic [15:0]             key_hdl;
	logic [2:0]              skip_eff;
	logic                    addr_ok;
	logic                    hdl_ok;
	logic                    mem_we;
	logic                    mem_re;
	logic [49:0]             wr_addr;
	logic [15:0]             wr_hdl;
	logic [PAYLOAD_BITS-1:0] wr_pay;

	always_comb begin
		case (req_q.table_req)
			TBL_PEER: begin
				base = AW'(KEY_TABLE_DEPTH);
				fill_sel = fill_q[1];
				cap_sel = CW'(KEY_TABLE_DEPTH);
			end
			TBL_SUB: begin
				base = AW'(2 * KEY_TABLE_DEPTH);
				fill_sel = fill_q[2];
				cap_sel = CW'(SUB_TABLE_DEPTH);
			end
			TBL_OWN: begin
				base = '0;
				fill_sel = fill_q[0];
				cap_sel = CW'(KEY_TABLE_DEPTH);
			end
			default: begin
				base = '0;
				fill_sel = '0;
				cap_sel = '0;
			end
		endcase
	end

	// key tables ignore the handle entirely
	assign key      = {req_q.address_type, req_q.address};
	assign key_hdl  = (req_q.table_req == TBL_SUB) ? req_q.handle : 16'd0;
	assign skip_eff = (req_q.mode == MODE_WRITE) ? 3'd0 : req_q.match_skip;
	assign addr_ok  = (key == '0) || (rd_addr_q == key);
	assign hdl_ok   = (key_hdl == '0) || (rd_hdl_q == key_hdl);

	assign mem_a  = base + AW'(idx_q) + AW'(cmd.rd_next);
	assign mem_we = cmd.wr_req || cmd.wr_shift;
	assign mem_re = cmd.rd_cur || cmd.rd_next;

	assign wr_addr = cmd.wr_shift ? rd_addr_q : key;
	assign wr_hdl  = cmd.wr_shift ? rd_hdl_q : key_hdl;
	assign wr_pay  = cmd.wr_shift ? rd_pay_q : req_q.payload[PAYLOAD_BITS-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_addr[mem_a] <= wr_addr;
			mem_hdl[mem_a]  <= wr_hdl;
			mem_pay[mem_a]  <= wr_pay;
		end
		if (mem_re) begin
			rd_addr_q <= mem_addr[mem_a];
			rd_hdl_q  <= mem_hdl[mem_a];
			rd_pay_q  <= mem_pay[mem_a];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
			found_addr_q <= '0;
			found_hdl_q <= '0;
			found_pay_q <= '0;
		end else if (cmd.load_found) begin
			found_addr_q <= rd_addr_q;
			found_hdl_q <= rd_hdl_q;
			found_pay_q <= rd_pay_q;
		end
		if (cmd.set_status) status_q <= cmd.status_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			seen_q <= '0;
		end else begin
			if (cmd.clr_scan) idx_q <= '0;
			else if (cmd.inc_idx) idx_q <= idx_q + CW'(1);
			if (cmd.clr_scan) seen_q <= '0;
			else if (cmd.inc_seen) seen_q <= seen_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q[0] <= '0;
			fill_q[1] <= '0;
			fill_q[2] <= '0;
		end else begin
			if (req_q.table_req == TBL_OWN) begin
				if (cmd.inc_fill) fill_q[0] <= fill_q[0] + CW'(1);
				else if (cmd.dec_fill) fill_q[0] <= fill_q[0] - CW'(1);
			end
			if (req_q.table_req == TBL_PEER) begin
				if (cmd.inc_fill) fill_q[1] <= fill_q[1] + CW'(1);
				else if (cmd.dec_fill) fill_q[1] <= fill_q[1] - CW'(1);
			end
			if (req_q.table_req == TBL_SUB) begin
				if (cmd.inc_fill) fill_q[2] <= fill_q[2] + CW'(1);
				else if (cmd.dec_fill) fill_q[2] <= fill_q[2] - CW'(1);
			end
		end
	end

	// result register, loaded once the previous item has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.status <= status_q;
			rsp_q.found_address_type <= found_addr_q[49:48];
			rsp_q.found_address <= found_addr_q[47:0];
			rsp_q.found_handle <= found_hdl_q;
			rsp_q.found_payload <= 64'(found_pay_q);
			rsp_q.entry_count <= 4'(fill_sel);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		sts.tbl_bad   = (req_q.table_req == TBL_BAD);
		sts.mode_bad  = (req_q.mode != MODE_READ) && (req_q.mode != MODE_WRITE) &&
			(req_q.mode != MODE_DELETE);
		sts.is_read   = (req_q.mode == MODE_READ);
		sts.is_write  = (req_q.mode == MODE_WRITE);
		sts.scan_end  = (idx_q >= fill_sel);
		sts.hit       = addr_ok && hdl_ok;
		sts.skip_more = (seen_q < skip_eff);
		sts.full      = (fill_sel >= cap_sel);
		sts.shift_end = ((CW+1)'(idx_q) + (CW+1)'(1)) >= (CW+1)'(fill_sel);
		sts.out_free  = !rsp_valid_q || rsp_ready;
	end

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q[0] <= CW'(KEY_TABLE_DEPTH)) && (fill_q[1] <= CW'(KEY_TABLE_DEPTH)) &&
		(fill_q[2] <= CW'(SUB_TABLE_DEPTH)))
		else $error("table count above capacity");

	a_wr_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_req |-> (idx_q < cap_sel))
		else $error("entry write outside the selected table");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid_q || rsp_ready))
		else $error("result overwritten before it was taken");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.status != ST_OK)) |->
		((rsp_q.found_payload == '0) && (rsp_q.found_address == '0)))
		else $error("found fields set on a failed item");

	a_shift_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec_fill |-> (fill_sel != '0))
		else $error("delete on an empty table");

endmodule

// File: sv/bond_record_table.sv
// top level of the bond record table: controller plus datapath
//
//  channel | signals                      | direction | payload
//  req     | req_valid, req_ready, req    | in        | brt_pkg::req_t
//  rsp     | rsp_valid, rsp_ready, rsp    | out       | brt_pkg::rsp_t
//
// an item with a bad table or mode goes straight to the result; else each
// entry scanned is read and then checked, and on delete each entry moved is
// read and then written one place lower, through the entry store's single port
// reset clears the table counts and the sequencer; the store is not cleared
// a new item is taken while a result waits; a stalled result holds the
// finished next item in the sequencer until the result register frees
module bond_record_table #(
	parameter int KEY_TABLE_DEPTH = brt_pkg::KEY_TABLE_DEPTH_DEF,
	parameter int SUB_TABLE_DEPTH = brt_pkg::SUB_TABLE_DEPTH_DEF,
	parameter int PAYLOAD_BITS    = brt_pkg::PAYLOAD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  brt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output brt_pkg::rsp_t rsp
);
	import brt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	brt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	brt_dpath #(
		.KEY_TABLE_DEPTH (KEY_TABLE_DEPTH),
		.SUB_TABLE_DEPTH (SUB_TABLE_DEPTH),
		.PAYLOAD_BITS    (PAYLOAD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
